### src/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition implies consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// condition holds at every edge
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

`endif

### src/smtc_pkg.sv
package smtc_pkg;

   // defaults for the top level parameters
   localparam int MEM_WORDS_DEF  = 262144;
   localparam int CACHE_SETS_DEF = 256;
   localparam int CACHE_WAYS_DEF = 4;

   // fixed translation and queue sizing
   localparam int TLB_ENTRIES = 128;
   localparam int FRAME_COUNT = 32;
   localparam int QUEUE_DEPTH = 2;

   localparam int LINE_WORDS = 4;
   localparam int TAG_W      = 22;
   localparam int PAGE_W     = 20;
   localparam int PADDR_W    = 31;

   localparam logic [PAGE_W-1:0] TLB_LIMIT = PAGE_W'(TLB_ENTRIES);

   localparam logic [15:0] LFSR_SEED = 16'hACE1;
   localparam logic [15:0] LFSR_TAPS = 16'hB400;

   typedef enum logic [1:0] {
      SEG_KUSEG = 2'd0,
      SEG_KSEG0 = 2'd1,
      SEG_KSEG1 = 2'd2,
      SEG_KSEG2 = 2'd3
   } seg_type;

   typedef enum logic {
      OP_READ  = 1'b0,
      OP_WRITE = 1'b1
   } op_type;

   // segment from the top address bits
   function automatic logic [1:0] decode_segment(input logic [31:0] va);
      logic [1:0] seg;
      if (!va[31]) begin
         seg = SEG_KUSEG;
      end else if (va[30:29] == 2'b00) begin
         seg = SEG_KSEG0;
      end else if (va[30:29] == 2'b01) begin
         seg = SEG_KSEG1;
      end else begin
         seg = SEG_KSEG2;
      end
      return seg;
   endfunction

   // galois lfsr, shift right
   function automatic logic [15:0] lfsr_next(input logic [15:0] l);
      logic [15:0] n;
      n = l >> 1;
      if (l[0]) begin
         n = n ^ LFSR_TAPS;
      end
      return n;
   endfunction

endpackage

### src/smtc_front.sv
module smtc_front import smtc_pkg::*; #(
   parameter int MEM_WORDS  = MEM_WORDS_DEF,
   parameter int CACHE_SETS = CACHE_SETS_DEF,
   parameter type entry_type = logic
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [31:0] req_vaddr,
   input  logic [31:0] req_wdata,
   input  logic        sweep_done,
   output logic        push_valid,
   input  logic        push_ready,
   output entry_type   push_data
);

   localparam int SET_W = $clog2(CACHE_SETS);
   localparam int MA    = $clog2(MEM_WORDS);

   // reciprocals for divide by constant: q is exact or one low
   localparam logic [32:0] M_FRAME = 33'(64'h1_0000_0000 / 64'(FRAME_COUNT));
   localparam logic [32:0] M_SET   = 33'(64'h1_0000_0000 / 64'(CACHE_SETS));
   localparam logic [32:0] M_MEM   = 33'(64'h1_0000_0000 / 64'(MEM_WORDS));
   localparam logic [30:0] D_FRAME = 31'(FRAME_COUNT);
   localparam logic [30:0] D_SET   = 31'(CACHE_SETS);
   localparam logic [30:0] D_MEM   = 31'(MEM_WORDS);

   typedef enum logic [1:0] {
      DIV_FRAME = 2'd0,
      DIV_SET   = 2'd1,
      DIV_MEM   = 2'd2
   } div_sel_type;

   typedef enum logic [4:0] {
      F_IDLE = 5'b00001,
      F_MUL  = 5'b00010,
      F_MULT = 5'b00100,
      F_CORR = 5'b01000,
      F_PUSH = 5'b10000
   } fstate_type;

   fstate_type        state_ff, state_in;
   div_sel_type       sel_ff, sel_in;
   logic              op_ff, op_in;
   logic [31:0]       va_ff, va_in;
   logic [31:0]       wd_ff, wd_in;
   logic [1:0]        seg_ff, seg_in;
   logic [30:0]       pa_ff, pa_in;
   logic              thit_ff, thit_in;
   logic [30:0]       x_ff, x_in;
   logic [30:0]       q_ff, q_in;
   logic [30:0]       t_ff, t_in;
   logic [SET_W-1:0]  set_ff, set_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;
   logic [MA-1:0]     base_ff, base_in;

   logic [32:0]       m_sel;
   logic [30:0]       d_sel;
   logic [63:0]       prod;
   logic [61:0]       t_full;
   logic [30:0]       r_raw, r_fix, q_fix;
   logic              r_ge;
   logic [30:0]       pa_tr;
   logic [1:0]        req_seg;

   // shared divide unit operands
   always_comb begin
      case (sel_ff)
         DIV_FRAME: begin m_sel = M_FRAME; d_sel = D_FRAME; end
         DIV_SET:   begin m_sel = M_SET;   d_sel = D_SET;   end
         default:   begin m_sel = M_MEM;   d_sel = D_MEM;   end
      endcase
   end

   assign prod   = {33'b0, x_ff} * {31'b0, m_sel};
   assign t_full = {31'b0, q_ff} * {31'b0, d_sel};
   assign r_raw  = x_ff - t_ff;
   assign r_ge   = r_raw >= d_sel;
   assign r_fix  = r_ge ? r_raw - d_sel : r_raw;
   assign q_fix  = q_ff + 31'(r_ge);
   assign pa_tr  = {r_fix[18:0], va_ff[11:0]};
   assign req_seg = decode_segment(req_vaddr);

   assign req_ready  = (state_ff == F_IDLE) && sweep_done;
   assign push_valid = (state_ff == F_PUSH);

   // classify and translate one request
   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      op_in    = op_ff;
      va_in    = va_ff;
      wd_in    = wd_ff;
      seg_in   = seg_ff;
      pa_in    = pa_ff;
      thit_in  = thit_ff;
      x_in     = x_ff;
      q_in     = q_ff;
      t_in     = t_ff;
      set_in   = set_ff;
      tag_in   = tag_ff;
      base_in  = base_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_valid && req_ready) begin
               op_in    = req_op;
               va_in    = req_vaddr;
               wd_in    = req_wdata;
               seg_in   = req_seg;
               state_in = F_MUL;
               case (req_seg)
                  SEG_KSEG0: begin
                     pa_in   = req_vaddr[30:0];
                     thit_in = 1'b0;
                     x_in    = {2'b0, req_vaddr[30:2]};
                     sel_in  = DIV_SET;
                  end
                  SEG_KSEG1: begin
                     pa_in   = {2'b0, req_vaddr[28:0]};
                     thit_in = 1'b0;
                     x_in    = {2'b0, req_vaddr[28:2], 2'b00};
                     sel_in  = DIV_MEM;
                  end
                  default: begin
                     // tlb holds page i in entry i and is never refilled
                     thit_in = req_vaddr[31:12] < TLB_LIMIT;
                     x_in    = {11'b0, req_vaddr[31:12]};
                     sel_in  = DIV_FRAME;
                  end
               endcase
            end
         end
         F_MUL: begin
            q_in     = prod[62:32];
            state_in = F_MULT;
         end
         F_MULT: begin
            t_in     = t_full[30:0];
            state_in = F_CORR;
         end
         F_CORR: begin
            case (sel_ff)
               DIV_FRAME: begin
                  pa_in    = pa_tr;
                  x_in     = {2'b0, pa_tr[30:2]};
                  sel_in   = DIV_SET;
                  state_in = F_MUL;
               end
               DIV_SET: begin
                  set_in   = r_fix[SET_W-1:0];
                  tag_in   = q_fix[TAG_W-1:0];
                  x_in     = {pa_ff[30:2], 2'b00};
                  sel_in   = DIV_MEM;
                  state_in = F_MUL;
               end
               default: begin
                  base_in  = r_fix[MA-1:0];
                  state_in = F_PUSH;
               end
            endcase
         end
         F_PUSH: begin
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      sel_ff  <= sel_in;
      op_ff   <= op_in;
      va_ff   <= va_in;
      wd_ff   <= wd_in;
      seg_ff  <= seg_in;
      pa_ff   <= pa_in;
      thit_ff <= thit_in;
      x_ff    <= x_in;
      q_ff    <= q_in;
      t_ff    <= t_in;
      set_ff  <= set_in;
      tag_ff  <= tag_in;
      base_ff <= base_in;
   end

   // queue entry
   always_comb begin
      push_data         = '0;
      push_data.op      = op_ff;
      push_data.wdata   = wd_ff;
      push_data.seg     = seg_ff;
      push_data.pa      = pa_ff;
      push_data.tlb_hit = thit_ff;
      push_data.set_idx = set_ff;
      push_data.tag     = tag_ff;
      push_data.base    = base_ff;
   end

endmodule

### src/smtc_queue.sv
`include "assert_macros.svh"

module smtc_queue import smtc_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH,
   parameter type entry_type = logic
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  entry_type push_data,
   output logic      pop_valid,
   input  logic      pop_ready,
   output entry_type pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   entry_type         entries_ff [DEPTH];
   logic [PW-1:0]     head_ff, head_in;
   logic [PW-1:0]     tail_ff, tail_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = count_ff != CW'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entries_ff[head_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and fill count update
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (do_push) begin
         tail_in = (tail_ff == PW'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (do_pop) begin
         head_in = (head_ff == PW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         entries_ff[tail_ff] <= push_data;
      end
   end

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(DEPTH), "queue overfilled")

endmodule

### src/smtc_back.sv
`include "assert_macros.svh"

module smtc_back import smtc_pkg::*; #(
   parameter int MEM_WORDS  = MEM_WORDS_DEF,
   parameter int CACHE_SETS = CACHE_SETS_DEF,
   parameter int CACHE_WAYS = CACHE_WAYS_DEF,
   parameter type entry_type = logic
) (
   input  logic               clock,
   input  logic               reset,
   output logic               sweep_done,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  entry_type          pop_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [31:0]        rsp_rdata,
   output logic [1:0]         rsp_segment,
   output logic [PADDR_W-1:0] rsp_paddr,
   output logic               rsp_tlb_hit,
   output logic               rsp_cache_hit
);

   localparam int MA         = $clog2(MEM_WORDS);
   localparam int SET_W      = $clog2(CACHE_SETS);
   localparam int WAY_W      = (CACHE_WAYS > 1) ? $clog2(CACHE_WAYS) : 1;
   localparam int DATA_DEPTH = CACHE_SETS * CACHE_WAYS * LINE_WORDS;
   localparam int DA         = $clog2(DATA_DEPTH);
   localparam int SWEEP_LEN  = (MEM_WORDS > DATA_DEPTH) ? MEM_WORDS : DATA_DEPTH;
   localparam int SWP_W      = $clog2(SWEEP_LEN + 1);
   localparam logic [16:0] VICTIM_M = 17'(32'h0001_0000 / CACHE_WAYS);

   typedef logic [CACHE_WAYS-1:0][TAG_W-1:0] row_type;

   function automatic row_type reset_row();
      row_type r;
      for (int w = 0; w < CACHE_WAYS; w++) begin
         r[w] = TAG_W'(w);
      end
      return r;
   endfunction

   localparam row_type RESET_ROW = reset_row();

   typedef enum logic [12:0] {
      B_SWEEP  = 13'b0000000000001,
      B_IDLE   = 13'b0000000000010,
      B_UNC    = 13'b0000000000100,
      B_UNC_RD = 13'b0000000001000,
      B_TAG    = 13'b0000000010000,
      B_CMP    = 13'b0000000100000,
      B_HIT_RD = 13'b0000001000000,
      B_VQ     = 13'b0000010000000,
      B_VR     = 13'b0000100000000,
      B_MW     = 13'b0001000000000,
      B_FRD    = 13'b0010000000000,
      B_FWR    = 13'b0100000000000,
      B_RESP   = 13'b1000000000000
   } bstate_type;

   // storage
   logic [31:0] main_mem [MEM_WORDS];
   logic [31:0] line_mem [DATA_DEPTH];
   row_type     tag_mem  [CACHE_SETS];

   bstate_type          state_ff, state_in;
   logic [SWP_W-1:0]    sweep_ff, sweep_in;
   logic [MA-1:0]       fillv_ff, fillv_in;
   entry_type           e_ff, e_in;
   row_type             row_ff, row_in;
   logic [WAY_W-1:0]    victim_ff, victim_in;
   logic [1:0]          fk_ff, fk_in;
   logic [31:0]         res_ff, res_in;
   logic                chit_ff, chit_in;
   logic [15:0]         lfsr_ff, lfsr_in;
   logic [16:0]         vq_ff, vq_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [31:0]         rsp_rdata_ff, rsp_rdata_in;
   logic [1:0]          rsp_seg_ff, rsp_seg_in;
   logic [PADDR_W-1:0]  rsp_pa_ff, rsp_pa_in;
   logic                rsp_thit_ff, rsp_thit_in;
   logic                rsp_chit_ff, rsp_chit_in;

   logic                mm_we;
   logic [MA-1:0]       mm_addr;
   logic [31:0]         mm_wd, mm_rd_ff;
   logic                lm_we;
   logic [DA-1:0]       lm_addr;
   logic [31:0]         lm_wd, lm_rd_ff;
   logic                tm_we;
   logic [SET_W-1:0]    tm_addr;
   row_type             tm_wd, tm_rd_ff;

   logic                hit_c;
   logic [WAY_W-1:0]    hit_way_c;
   logic [WAY_W-1:0]    way_mux;
   logic [1:0]          k_mux;
   logic [DA-3:0]       line_idx;
   logic [1:0]          addend;
   logic [MA:0]         mi_sum;
   logic [MA-1:0]       mi_wrap;
   logic [32:0]         vprod;
   logic [16:0]         vr_raw, vr_fix;
   row_type             row_upd;

   // main memory, one port
   always_ff @(posedge clock) begin
      if (mm_we) begin
         main_mem[mm_addr] <= mm_wd;
      end
      mm_rd_ff <= main_mem[mm_addr];
   end

   // cache data memory
   always_ff @(posedge clock) begin
      if (lm_we) begin
         line_mem[lm_addr] <= lm_wd;
      end
      lm_rd_ff <= line_mem[lm_addr];
   end

   // cache tag memory, one row per set
   always_ff @(posedge clock) begin
      if (tm_we) begin
         tag_mem[tm_addr] <= tm_wd;
      end
      tm_rd_ff <= tag_mem[tm_addr];
   end

   // lowest matching way wins
   always_comb begin
      hit_c     = 1'b0;
      hit_way_c = '0;
      for (int w = CACHE_WAYS - 1; w >= 0; w--) begin
         if (tm_rd_ff[w] == e_ff.tag) begin
            hit_c     = 1'b1;
            hit_way_c = WAY_W'(w);
         end
      end
   end

   // memory index wrap for the request word or a fill word
   assign addend  = (state_ff == B_FRD) ? fk_ff : e_ff.pa[1:0];
   assign mi_sum  = {1'b0, e_ff.base} + (MA + 1)'(addend);
   assign mi_wrap = (mi_sum >= (MA + 1)'(MEM_WORDS)) ?
                    MA'(mi_sum - (MA + 1)'(MEM_WORDS)) : mi_sum[MA-1:0];

   // data address: (way * sets + set) * 4 + word
   assign way_mux  = (state_ff == B_CMP) ? hit_way_c : victim_ff;
   assign k_mux    = (state_ff == B_FWR) ? fk_ff : e_ff.pa[1:0];
   assign line_idx = (DA - 2)'(way_mux) * (DA - 2)'(CACHE_SETS) + (DA - 2)'(e_ff.set_idx);

   // victim way = lfsr mod ways by reciprocal
   assign vprod  = 33'(lfsr_ff) * 33'(VICTIM_M);
   assign vr_raw = {1'b0, lfsr_ff} - vq_ff * 17'(CACHE_WAYS);
   assign vr_fix = (vr_raw >= 17'(CACHE_WAYS)) ? vr_raw - 17'(CACHE_WAYS) : vr_raw;

   always_comb begin
      row_upd            = row_ff;
      row_upd[victim_ff] = e_ff.tag;
   end

   assign pop_ready  = (state_ff == B_IDLE);
   assign sweep_done = (state_ff != B_SWEEP);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      fillv_in     = fillv_ff;
      e_in         = e_ff;
      row_in       = row_ff;
      victim_in    = victim_ff;
      fk_in        = fk_ff;
      res_in       = res_ff;
      chit_in      = chit_ff;
      lfsr_in      = lfsr_ff;
      vq_in        = vq_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_rdata_in = rsp_rdata_ff;
      rsp_seg_in   = rsp_seg_ff;
      rsp_pa_in    = rsp_pa_ff;
      rsp_thit_in  = rsp_thit_ff;
      rsp_chit_in  = rsp_chit_ff;
      mm_we        = 1'b0;
      mm_addr      = mi_wrap;
      mm_wd        = e_ff.wdata;
      lm_we        = 1'b0;
      lm_addr      = {line_idx, k_mux};
      lm_wd        = e_ff.wdata;
      tm_we        = 1'b0;
      tm_addr      = e_ff.set_idx;
      tm_wd        = row_upd;
      case (state_ff)
         B_SWEEP: begin
            // load memory with its index and the cache with its startup lines
            mm_we   = sweep_ff < SWP_W'(MEM_WORDS);
            mm_addr = sweep_ff[MA-1:0];
            mm_wd   = 32'(sweep_ff);
            lm_we   = sweep_ff < SWP_W'(DATA_DEPTH);
            lm_addr = sweep_ff[DA-1:0];
            lm_wd   = 32'(fillv_ff);
            tm_we   = sweep_ff < SWP_W'(CACHE_SETS);
            tm_addr = sweep_ff[SET_W-1:0];
            tm_wd   = RESET_ROW;
            fillv_in = (fillv_ff == MA'(MEM_WORDS - 1)) ? '0 : fillv_ff + 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == SWP_W'(SWEEP_LEN - 1)) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (pop_valid) begin
               e_in     = pop_data;
               state_in = (pop_data.seg == SEG_KSEG1) ? B_UNC : B_TAG;
            end
         end
         B_UNC: begin
            mm_we    = (e_ff.op == OP_WRITE);
            state_in = B_UNC_RD;
         end
         B_UNC_RD: begin
            res_in   = (e_ff.op == OP_WRITE) ? e_ff.wdata : mm_rd_ff;
            chit_in  = 1'b0;
            state_in = B_RESP;
         end
         B_TAG: begin
            state_in = B_CMP;
         end
         B_CMP: begin
            row_in  = tm_rd_ff;
            chit_in = hit_c;
            if (hit_c) begin
               if (e_ff.op == OP_WRITE) begin
                  mm_we    = 1'b1;
                  lm_we    = 1'b1;
                  res_in   = e_ff.wdata;
                  state_in = B_RESP;
               end else begin
                  state_in = B_HIT_RD;
               end
            end else begin
               lfsr_in  = lfsr_next(lfsr_ff);
               state_in = B_VQ;
            end
         end
         B_HIT_RD: begin
            res_in   = lm_rd_ff;
            state_in = B_RESP;
         end
         B_VQ: begin
            vq_in    = vprod[32:16];
            state_in = B_VR;
         end
         B_VR: begin
            victim_in = vr_fix[WAY_W-1:0];
            fk_in     = '0;
            state_in  = (e_ff.op == OP_WRITE) ? B_MW : B_FRD;
         end
         B_MW: begin
            // write-through before the line fill
            mm_we    = 1'b1;
            state_in = B_FRD;
         end
         B_FRD: begin
            state_in = B_FWR;
         end
         B_FWR: begin
            lm_we = 1'b1;
            lm_wd = mm_rd_ff;
            if (fk_ff == e_ff.pa[1:0]) begin
               res_in = (e_ff.op == OP_WRITE) ? e_ff.wdata : mm_rd_ff;
            end
            if (fk_ff == 2'(LINE_WORDS - 1)) begin
               tm_we    = 1'b1;
               state_in = B_RESP;
            end else begin
               fk_in    = fk_ff + 1'b1;
               state_in = B_FRD;
            end
         end
         B_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_rdata_in = res_ff;
               rsp_seg_in   = e_ff.seg;
               rsp_pa_in    = e_ff.pa;
               rsp_thit_in  = e_ff.tlb_hit;
               rsp_chit_in  = chit_ff;
               state_in     = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_SWEEP;
         sweep_ff     <= '0;
         fillv_ff     <= '0;
         lfsr_ff      <= LFSR_SEED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         fillv_ff     <= fillv_in;
         lfsr_ff      <= lfsr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      e_ff         <= e_in;
      row_ff       <= row_in;
      victim_ff    <= victim_in;
      fk_ff        <= fk_in;
      res_ff       <= res_in;
      chit_ff      <= chit_in;
      vq_ff        <= vq_in;
      rsp_rdata_ff <= rsp_rdata_in;
      rsp_seg_ff   <= rsp_seg_in;
      rsp_pa_ff    <= rsp_pa_in;
      rsp_thit_ff  <= rsp_thit_in;
      rsp_chit_ff  <= rsp_chit_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_rdata     = rsp_rdata_ff;
   assign rsp_segment   = rsp_seg_ff;
   assign rsp_paddr     = rsp_pa_ff;
   assign rsp_tlb_hit   = rsp_thit_ff;
   assign rsp_cache_hit = rsp_chit_ff;

   `ASSERT_NEXT(a_resp_load, clock, reset, (state_ff == B_RESP) && (!rsp_valid_ff || rsp_ready), rsp_valid_ff, "result not presented after load")
   `ASSERT_IMPLIES(a_sweep_quiet, clock, reset, state_ff == B_SWEEP, !pop_valid, "request queued during clearing pass")
   `ASSERT_IMPLIES(a_victim_range, clock, reset, state_ff == B_FRD, {1'b0, victim_ff} < (WAY_W + 1)'(CACHE_WAYS), "victim way out of range")

endmodule

### src/segment_mmu_tlb_cache_access_unit.sv
// channel   | direction | handshake            | payload
// req       | in        | req_valid/req_ready  | req_op, req_vaddr, req_wdata
// rsp       | out       | rsp_valid/rsp_ready  | rsp_rdata, rsp_segment, rsp_paddr,
//           |           |                      | rsp_tlb_hit, rsp_cache_hit
//
// front: three constant divides for mapped, two for kseg0, one for kseg1, all on one shared divide unit
// back: a hit is served from the cache; a miss does a line fill over the single main memory port
// (a write miss writes memory first), and kseg1 accesses main memory directly;
// front and back overlap through a two entry queue
// after reset a clearing pass over max(MEM_WORDS, 4*CACHE_SETS*CACHE_WAYS) addresses loads
// memory and cache; no request is taken until it ends
// a result waiting on rsp_ready stalls only the back; the front keeps taking requests
// until the queue fills
module segment_mmu_tlb_cache_access_unit import smtc_pkg::*; #(
   parameter int MEM_WORDS  = MEM_WORDS_DEF,
   parameter int CACHE_SETS = CACHE_SETS_DEF,
   parameter int CACHE_WAYS = CACHE_WAYS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_op,
   input  logic [31:0]        req_vaddr,
   input  logic [31:0]        req_wdata,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [31:0]        rsp_rdata,
   output logic [1:0]         rsp_segment,
   output logic [PADDR_W-1:0] rsp_paddr,
   output logic               rsp_tlb_hit,
   output logic               rsp_cache_hit
);

   localparam int SET_W = $clog2(CACHE_SETS);
   localparam int MA    = $clog2(MEM_WORDS);

   typedef struct packed {
      logic               op;
      logic [31:0]        wdata;
      logic [1:0]         seg;
      logic [PADDR_W-1:0] pa;
      logic               tlb_hit;
      logic [SET_W-1:0]   set_idx;
      logic [TAG_W-1:0]   tag;
      logic [MA-1:0]      base;
   } entry_type;

   entry_type push_data, pop_data;
   logic      push_valid, push_ready, pop_valid, pop_ready, sweep_done;

   // decode and translate
   smtc_front #(
      .MEM_WORDS  (MEM_WORDS),
      .CACHE_SETS (CACHE_SETS),
      .entry_type (entry_type)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_op     (req_op),
      .req_vaddr  (req_vaddr),
      .req_wdata  (req_wdata),
      .sweep_done (sweep_done),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // decoupling queue
   smtc_queue #(
      .DEPTH      (QUEUE_DEPTH),
      .entry_type (entry_type)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // cache and memory access
   smtc_back #(
      .MEM_WORDS  (MEM_WORDS),
      .CACHE_SETS (CACHE_SETS),
      .CACHE_WAYS (CACHE_WAYS),
      .entry_type (entry_type)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .sweep_done    (sweep_done),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .pop_data      (pop_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_rdata     (rsp_rdata),
      .rsp_segment   (rsp_segment),
      .rsp_paddr     (rsp_paddr),
      .rsp_tlb_hit   (rsp_tlb_hit),
      .rsp_cache_hit (rsp_cache_hit)
   );

endmodule
